>>> design/aabb_pkg.sv
`timescale 1ns / 1ps

package aabb_pkg;

   localparam int COORD_BITS = 32;
   localparam int PUSH_BITS  = 36;
   localparam int DEPTH_BITS = 35;
   localparam int NUM_AXES   = 3;
   localparam int NUM_STAGES = 6;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] moving_min_x;
      logic signed [COORD_BITS-1:0] moving_min_y;
      logic signed [COORD_BITS-1:0] moving_min_z;
      logic signed [COORD_BITS-1:0] moving_max_x;
      logic signed [COORD_BITS-1:0] moving_max_y;
      logic signed [COORD_BITS-1:0] moving_max_z;
      logic signed [COORD_BITS-1:0] static_min_x;
      logic signed [COORD_BITS-1:0] static_min_y;
      logic signed [COORD_BITS-1:0] static_min_z;
      logic signed [COORD_BITS-1:0] static_max_x;
      logic signed [COORD_BITS-1:0] static_max_y;
      logic signed [COORD_BITS-1:0] static_max_z;
   } req_type;

   typedef struct packed {
      logic                         colliding;
      logic signed [PUSH_BITS-1:0]  push_x;
      logic signed [PUSH_BITS-1:0]  push_y;
      logic signed [PUSH_BITS-1:0]  push_z;
      logic        [DEPTH_BITS-1:0] depth;
   } rsp_type;

endpackage

>>> design/aabb_min_translation.sv
`timescale 1ns / 1ps

// Minimum translation vector between a moving and a static axis-aligned box.
// Each transfer on req carries both boxes as signed Q16.16 corners; each
// produces exactly one transfer on rsp with the collision flag, the push for
// the moving box along the axis of least overlap, and that overlap, all in
// half-LSB units. The datapath is a six-stage pipeline (corner sums, centre
// and extent differences, absolute difference, overlap, axis compare, push
// sign); a new pair is taken every cycle unless back-pressure stops req. Each
// stage holds its own valid bit and stalls only when it is full and the stage
// after it cannot move, so back-pressure on rsp fills bubbles before it stops
// req.
module aabb_min_translation
   import aabb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int C = COORD_BITS;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   // stage valid bits and per-stage advance
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES:0]   ready;

   always_comb begin
      ready[NUM_STAGES] = rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = ready[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // unpack corners per axis
   logic signed [C-1:0] mmin [NUM_AXES];
   logic signed [C-1:0] mmax [NUM_AXES];
   logic signed [C-1:0] smin [NUM_AXES];
   logic signed [C-1:0] smax [NUM_AXES];

   always_comb begin
      mmin[0] = req_data.moving_min_x;
      mmin[1] = req_data.moving_min_y;
      mmin[2] = req_data.moving_min_z;
      mmax[0] = req_data.moving_max_x;
      mmax[1] = req_data.moving_max_y;
      mmax[2] = req_data.moving_max_z;
      smin[0] = req_data.static_min_x;
      smin[1] = req_data.static_min_y;
      smin[2] = req_data.static_min_z;
      smax[0] = req_data.static_max_x;
      smax[1] = req_data.static_max_y;
      smax[2] = req_data.static_max_z;
   end

   // stage 1: corner sums and extents
   logic signed [C:0] s1_ssum_ff [NUM_AXES];
   logic signed [C:0] s1_msum_ff [NUM_AXES];
   logic signed [C:0] s1_sext_ff [NUM_AXES];
   logic signed [C:0] s1_mext_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            s1_ssum_ff[a] <= $signed({smin[a][C-1], smin[a]}) + $signed({smax[a][C-1], smax[a]});
            s1_msum_ff[a] <= $signed({mmin[a][C-1], mmin[a]}) + $signed({mmax[a][C-1], mmax[a]});
            s1_sext_ff[a] <= $signed({smax[a][C-1], smax[a]}) - $signed({smin[a][C-1], smin[a]});
            s1_mext_ff[a] <= $signed({mmax[a][C-1], mmax[a]}) - $signed({mmin[a][C-1], mmin[a]});
         end
      end
   end

   // stage 2: doubled centre difference and doubled half-extent sum
   logic signed [C+1:0] s2_diff_ff [NUM_AXES];
   logic signed [C+1:0] s2_ext_ff  [NUM_AXES];

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            s2_diff_ff[a] <= $signed({s1_ssum_ff[a][C], s1_ssum_ff[a]})
                           - $signed({s1_msum_ff[a][C], s1_msum_ff[a]});
            s2_ext_ff[a]  <= $signed({s1_sext_ff[a][C], s1_sext_ff[a]})
                           + $signed({s1_mext_ff[a][C], s1_mext_ff[a]});
         end
      end
   end

   // stage 3: absolute centre difference, direction flag
   logic signed [C+1:0] s3_ext_ff  [NUM_AXES];
   logic        [C+1:0] s3_absd_ff [NUM_AXES];
   logic [NUM_AXES-1:0] s3_dpos_ff;

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            s3_ext_ff[a]  <= s2_ext_ff[a];
            s3_absd_ff[a] <= s2_diff_ff[a][C+1] ? (C+2)'(-s2_diff_ff[a])
                                                : (C+2)'(s2_diff_ff[a]);
            s3_dpos_ff[a] <= !s2_diff_ff[a][C+1] && (s2_diff_ff[a] != '0);
         end
      end
   end

   // stage 4: overlap per axis
   logic signed [C+2:0] s4_ovl_ff [NUM_AXES];
   logic [NUM_AXES-1:0] s4_dpos_ff;

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         s4_dpos_ff <= s3_dpos_ff;
         for (int a = 0; a < NUM_AXES; a++) begin
            s4_ovl_ff[a] <= $signed({s3_ext_ff[a][C+1], s3_ext_ff[a]})
                          - $signed({1'b0, s3_absd_ff[a]});
         end
      end
   end

   // stage 5: collision test and axis pick
   logic                s5_hit_ff;
   logic                s5_neg_ff;
   axis_type            s5_axis_ff;
   logic signed [C+2:0] s5_ovl_ff;
   logic [NUM_AXES-1:0] ovl_pos;
   axis_type            axis_sel;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         ovl_pos[a] = !s4_ovl_ff[a][C+2] && (s4_ovl_ff[a] != '0);
      end
      priority if (s4_ovl_ff[0] < s4_ovl_ff[1] && s4_ovl_ff[0] < s4_ovl_ff[2]) begin
         axis_sel = AXIS_X;
      end else if (s4_ovl_ff[1] < s4_ovl_ff[2]) begin
         axis_sel = AXIS_Y;
      end else begin
         axis_sel = AXIS_Z;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         s5_hit_ff  <= &ovl_pos;
         s5_axis_ff <= axis_sel;
         unique case (axis_sel)
            AXIS_X: begin
               s5_ovl_ff <= s4_ovl_ff[0];
               s5_neg_ff <= s4_dpos_ff[0];
            end
            AXIS_Y: begin
               s5_ovl_ff <= s4_ovl_ff[1];
               s5_neg_ff <= s4_dpos_ff[1];
            end
            default: begin
               s5_ovl_ff <= s4_ovl_ff[2];
               s5_neg_ff <= s4_dpos_ff[2];
            end
         endcase
      end
   end

   // stage 6: signed push on the picked axis, output register
   rsp_type                    rsp_ff, rsp_in;
   logic signed [PUSH_BITS-1:0] push_mag;
   logic signed [PUSH_BITS-1:0] push_val;

   always_comb begin
      push_mag = PUSH_BITS'(s5_ovl_ff);
      push_val = s5_neg_ff ? -push_mag : push_mag;
      rsp_in   = '0;
      if (s5_hit_ff) begin
         rsp_in.colliding = 1'b1;
         rsp_in.depth     = DEPTH_BITS'($unsigned(s5_ovl_ff));
         unique case (s5_axis_ff)
            AXIS_X:  rsp_in.push_x = push_val;
            AXIS_Y:  rsp_in.push_y = push_val;
            default: rsp_in.push_z = push_val;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ready[5]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench
   import aabb_pkg::*;
();

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [63:0] wide_type;
   typedef enum int {AXIS_X, AXIS_Y, AXIS_Z} axis_type;

   localparam coord_type C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam int        U     = 65536;
   localparam int        RANDOM_PAIRS_PER_PHASE = 425;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rsp_type mtv_expected[$];
   int      mismatch_count;
   int      send_idle_pct;
   int      recv_stall_pct;

   aabb_min_translation u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Minimum translation vector for one pair of boxes, in half-LSB units.
   function automatic rsp_type predict_mtv(input req_type r);
      wide_type m_lo[3], m_hi[3], s_lo[3], s_hi[3];
      wide_type diff2[3], ovl[3], push[3];
      wide_type extent_sum, abs_diff;
      axis_type pick;
      rsp_type  res;
      m_lo[AXIS_X] = r.moving_min_x;
      m_lo[AXIS_Y] = r.moving_min_y;
      m_lo[AXIS_Z] = r.moving_min_z;
      m_hi[AXIS_X] = r.moving_max_x;
      m_hi[AXIS_Y] = r.moving_max_y;
      m_hi[AXIS_Z] = r.moving_max_z;
      s_lo[AXIS_X] = r.static_min_x;
      s_lo[AXIS_Y] = r.static_min_y;
      s_lo[AXIS_Z] = r.static_min_z;
      s_hi[AXIS_X] = r.static_max_x;
      s_hi[AXIS_Y] = r.static_max_y;
      s_hi[AXIS_Z] = r.static_max_z;
      for (int k = 0; k < NUM_AXES; k++) begin
         diff2[k]   = (s_lo[k] + s_hi[k]) - (m_lo[k] + m_hi[k]);
         extent_sum = (s_hi[k] - s_lo[k]) + (m_hi[k] - m_lo[k]);
         abs_diff   = diff2[k] < 0 ? -diff2[k] : diff2[k];
         ovl[k]     = extent_sum - abs_diff;
         push[k]    = '0;
      end
      res = '0;
      if (ovl[AXIS_X] > 0 && ovl[AXIS_Y] > 0 && ovl[AXIS_Z] > 0) begin
         // X wins only when strictly smallest; ties fall through to Y, then Z
         if (ovl[AXIS_X] < ovl[AXIS_Y] && ovl[AXIS_X] < ovl[AXIS_Z])
            pick = AXIS_X;
         else if (ovl[AXIS_Y] < ovl[AXIS_Z])
            pick = AXIS_Y;
         else
            pick = AXIS_Z;
         push[pick]    = diff2[pick] > 0 ? -ovl[pick] : ovl[pick];
         res.colliding = 1'b1;
         res.push_x    = push[AXIS_X][PUSH_BITS-1:0];
         res.push_y    = push[AXIS_Y][PUSH_BITS-1:0];
         res.push_z    = push[AXIS_Z][PUSH_BITS-1:0];
         res.depth     = ovl[pick][DEPTH_BITS-1:0];
      end
      return res;
   endfunction

   function automatic req_type box_pair(
      input coord_type m_lo_x, m_lo_y, m_lo_z, m_hi_x, m_hi_y, m_hi_z,
      input coord_type s_lo_x, s_lo_y, s_lo_z, s_hi_x, s_hi_y, s_hi_z);
      req_type r;
      r.moving_min_x = m_lo_x;
      r.moving_min_y = m_lo_y;
      r.moving_min_z = m_lo_z;
      r.moving_max_x = m_hi_x;
      r.moving_max_y = m_hi_y;
      r.moving_max_z = m_hi_z;
      r.static_min_x = s_lo_x;
      r.static_min_y = s_lo_y;
      r.static_min_z = s_lo_z;
      r.static_max_x = s_hi_x;
      r.static_max_y = s_hi_y;
      r.static_max_z = s_hi_z;
      return r;
   endfunction

   // Mostly overlapping pairs at random scales; some noise, some separated,
   // some with equal overlaps on several axes.
   function automatic req_type random_pair();
      coord_type m_lo[3], m_hi[3], s_lo[3], s_hi[3];
      coord_type base, offs, delta, tmp;
      int        kind, span, ext_m, ext_s;
      kind = $urandom_range(99);
      for (int k = 0; k < NUM_AXES; k++) begin
         if (kind < 15) begin
            m_lo[k] = $urandom;
            m_hi[k] = $urandom;
            s_lo[k] = $urandom;
            s_hi[k] = $urandom;
         end else begin
            span  = $urandom_range(30, 1);
            base  = $signed($urandom) >>> $urandom_range(24, 0);
            ext_m = $urandom_range((1 << span) - 1, 0);
            ext_s = $urandom_range((1 << span) - 1, 0);
            if (kind < 25)
               offs = $signed($urandom) >>> $urandom_range(31, 1);
            else
               offs = $signed($urandom_range(ext_m + ext_s, 0)) - ext_s;
            m_lo[k] = base;
            m_hi[k] = base + ext_m;
            s_lo[k] = base + offs;
            s_hi[k] = base + offs + ext_s;
            if ($urandom_range(19) == 0) begin
               tmp     = m_lo[k];
               m_lo[k] = m_hi[k];
               m_hi[k] = tmp;
            end
         end
      end
      // a common shift keeps both the centre difference and the extents
      if (kind >= 88) begin
         for (int k = 1; k < NUM_AXES; k++) begin
            if (k == 1 || $urandom_range(1) == 1) begin
               delta   = $signed($urandom) >>> 8;
               m_lo[k] = m_lo[0] + delta;
               m_hi[k] = m_hi[0] + delta;
               s_lo[k] = s_lo[0] + delta;
               s_hi[k] = s_hi[0] + delta;
            end
         end
      end
      return box_pair(m_lo[0], m_lo[1], m_lo[2], m_hi[0], m_hi[1], m_hi[2],
                      s_lo[0], s_lo[1], s_lo[2], s_hi[0], s_hi[1], s_hi[2]);
   endfunction

   task automatic send_pair(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Scoreboard: predict on each request transfer, check each response transfer.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (mtv_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: col=%0b push=%0d/%0d/%0d depth=%0d",
                           rsp_data.colliding, rsp_data.push_x, rsp_data.push_y,
                           rsp_data.push_z, rsp_data.depth);
            end else begin
               want = mtv_expected.pop_front();
               if (rsp_data.colliding !== want.colliding || rsp_data.push_x !== want.push_x ||
                   rsp_data.push_y !== want.push_y || rsp_data.push_z !== want.push_z ||
                   rsp_data.depth !== want.depth) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected col=%0b push=%0d/%0d/%0d depth=%0d, ",
                               "got col=%0b push=%0d/%0d/%0d depth=%0d"},
                              want.colliding, want.push_x, want.push_y, want.push_z,
                              want.depth, rsp_data.colliding, rsp_data.push_x,
                              rsp_data.push_y, rsp_data.push_z, rsp_data.depth);
               end
            end
         end
         if (req_valid && req_ready)
            mtv_expected.push_back(predict_mtv(req_data));
      end
   end

   task automatic test_field_extremes();
      send_pair(box_pair('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
      send_pair(box_pair(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                         C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
      send_pair(box_pair(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                         C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
      send_pair(box_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                         C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
      // deep overlap pushed negative
      send_pair(box_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                         C_MIN + 1, C_MIN + 1, C_MIN + 1, C_MAX, C_MAX, C_MAX));
      send_pair(box_pair(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                         C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
      send_pair(box_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                         C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
   endtask

   task automatic test_axis_selection();
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 8*U, 2*U, 1*U, 18*U, 12*U, 11*U));
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 2*U, 8*U, 1*U, 12*U, 18*U, 11*U));
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 2*U, 1*U, 8*U, 12*U, 11*U, 18*U));
      // equal overlaps: X never wins a tie, Y loses a tie to Z
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 8*U, 8*U, 1*U, 18*U, 18*U, 11*U));
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 8*U, 1*U, 8*U, 18*U, 11*U, 18*U));
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 1*U, 8*U, 8*U, 11*U, 18*U, 18*U));
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 8*U, 8*U, 8*U, 18*U, 18*U, 18*U));
   endtask

   task automatic test_push_direction();
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, -8*U, 2*U, 1*U, 2*U, 12*U, 11*U));
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 2*U, -8*U, 1*U, 12*U, 2*U, 11*U));
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 2*U, 1*U, -8*U, 12*U, 11*U, 2*U));
      // concentric on the picked axis pushes positive, then a narrow X overlap pushes negative
      send_pair(box_pair(0, 0, 0, 2*U, 10*U, 10*U, 0, 0, 0, 2*U, 10*U, 10*U));
      send_pair(box_pair(0, 0, 0, 10, 10*U, 10*U, 9, 0, 0, 19, 10*U, 10*U));
   endtask

   task automatic test_degenerate_boxes();
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 10*U, 0, 0, 20*U, 10*U, 10*U));
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 0, -10*U, 0, 10*U, 0, 10*U));
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 0, 0, 11*U, 10*U, 10*U, 20*U));
      send_pair(box_pair(5*U, 5*U, 5*U, 5*U, 5*U, 5*U, 0, 0, 0, 10*U, 10*U, 10*U));
      // inverted boxes
      send_pair(box_pair(10*U, 10*U, 10*U, 0, 0, 0,
                         -100*U, -100*U, -100*U, 100*U, 100*U, 100*U));
      send_pair(box_pair(0, 0, 0, 10*U, 10*U, 10*U, 10*U, 10*U, 10*U, 0, 0, 0));
      send_pair(box_pair(10*U, 10*U, 10*U, 0, 0, 0, 10*U, 10*U, 10*U, 0, 0, 0));
   endtask

   task automatic test_random_pairs(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count)
         send_pair(random_pair());
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      mismatch_count = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_axis_selection();
      test_push_direction();
      test_degenerate_boxes();
      test_random_pairs(RANDOM_PAIRS_PER_PHASE, 0, 0);
      test_random_pairs(RANDOM_PAIRS_PER_PHASE, 46, 0);
      test_random_pairs(RANDOM_PAIRS_PER_PHASE, 0, 46);
      test_random_pairs(RANDOM_PAIRS_PER_PHASE, 25, 25);
      req_valid <= 1'b0;
      @(posedge clock);
      while (mtv_expected.size() != 0)
         @(posedge clock);
      repeat (NUM_STAGES * 4) @(posedge clock);
      if (mismatch_count == 0 && mtv_expected.size() == 0)
         $display("aabb_min_translation regression: pass");
      else
         $display("aabb_min_translation regression: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("aabb_min_translation regression: fail");
      $finish;
   end

endmodule

>>> filelist.f
design/aabb_pkg.sv
design/aabb_min_translation.sv
verif/testbench.sv
